// ===== rtl/spq_pkg.sv =====
// Package: widths, operation and status codes, and the command bundle sent to the cell row.
package spq_pkg;

  localparam int CAPACITY   = 16;
  localparam int DATA_WIDTH = 32;
  localparam int COUNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int POS_W      = 4;

  typedef logic signed [DATA_WIDTH-1:0] data_t;
  typedef logic [COUNT_W-1:0]           count_t;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_READ   = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_MISSING = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  // Command broadcast to every cell of the row
  typedef struct packed {
    logic  ins;
    logic  rem;
    data_t value;
  } cell_cmd_t;

endpackage

// ===== rtl/spq_cell.sv =====
// One storage cell of the sorted row: holds one entry and trades it with its neighbors.
module spq_cell (
  input  logic              clk,
  input  spq_pkg::cell_cmd_t cmd,
  input  logic              valid,
  input  spq_pkg::data_t    prev_entry,
  input  spq_pkg::data_t    next_entry,
  input  logic              prev_lt,
  input  logic              prev_found,
  output spq_pkg::data_t    entry,
  output logic              lt,
  output logic              found
);
  import spq_pkg::*;

  data_t entry_r;
  data_t entry_nxt;

  // Compare own entry against the broadcast value
  assign lt    = valid && (entry_r < cmd.value);
  assign found = prev_found || (valid && (entry_r == cmd.value));
  assign entry = entry_r;

  // Keep, take the new value, shift up from the left or shift down from the right
  always_comb begin
    entry_nxt = entry_r;
    if (cmd.ins && !lt) begin
      entry_nxt = prev_lt ? cmd.value : prev_entry;
    end else if (cmd.rem && found) begin
      entry_nxt = next_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

// ===== rtl/sorted_priority_queue_core.sv =====
// Top level: sorted priority queue built from a row of compare-and-shift cells.
//
// The block accepts a new item (insert, remove, or read at a rank) every
// cycle while the input is not stalled; its result is loaded into the
// output register on acceptance. All cells compare against the
// broadcast value in parallel and shift by one place toward their neighbor in
// the same edge, so the rate is set by that single cell-row update; the
// remove search ripples a one-bit match flag through the row. A held result
// stalls the input only while the output side is stalled.
module sorted_priority_queue_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_op,
  input  spq_pkg::data_t        in_value,
  input  logic [3:0]            in_position,
  input  logic                  in_from_back,
  output logic                  out_valid,
  input  logic                  out_stall,
  output spq_pkg::data_t        out_read_value,
  output logic [1:0]            out_status
);
  import spq_pkg::*;

  count_t    fill_r;
  count_t    fill_nxt;
  logic      out_valid_r;
  data_t     out_read_value_r;
  data_t     out_read_value_nxt;
  status_t   out_status_r;
  status_t   out_status_nxt;

  logic      in_acc;
  logic      full;
  cell_cmd_t cmd;
  count_t    pos_ext;
  count_t    read_idx;
  logic      pos_ok;

  data_t     entry_w [CAPACITY];
  logic      lt_w    [CAPACITY];
  logic      found_w [CAPACITY];

  assign in_stall = out_valid_r && out_stall;
  assign in_acc   = in_valid && !in_stall;
  assign full     = (fill_r == count_t'(CAPACITY));

  // Build the row command; only accepted items change the store
  always_comb begin
    cmd.ins   = in_acc && (in_op == OP_INSERT) && !full;
    cmd.rem   = in_acc && (in_op == OP_REMOVE);
    cmd.value = in_value;
  end

  // Cell row
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    data_t prev_e;
    data_t next_e;
    logic  prev_l;
    logic  prev_f;
    if (i == 0) begin : g_first
      assign prev_e = in_value;
      assign prev_l = 1'b1;
      assign prev_f = 1'b0;
    end else begin : g_mid
      assign prev_e = entry_w[i-1];
      assign prev_l = lt_w[i-1];
      assign prev_f = found_w[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign next_e = '0;
    end else begin : g_inner
      assign next_e = entry_w[i+1];
    end
    spq_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .valid      (count_t'(i) < fill_r),
      .prev_entry (prev_e),
      .next_entry (next_e),
      .prev_lt    (prev_l),
      .prev_found (prev_f),
      .entry      (entry_w[i]),
      .lt         (lt_w[i]),
      .found      (found_w[i])
    );
  end

  // Resolve the read rank to a slot
  assign pos_ext  = count_t'(in_position);
  assign pos_ok   = pos_ext < fill_r;
  assign read_idx = in_from_back ? (fill_r - count_t'(1) - pos_ext) : pos_ext;

  // Compute result and next fill count
  always_comb begin
    fill_nxt           = fill_r;
    out_read_value_nxt = '0;
    out_status_nxt     = ST_MISSING;
    unique case (in_op)
      OP_INSERT: begin
        if (full) begin
          out_status_nxt = ST_FULL;
        end else begin
          out_status_nxt = ST_OK;
          fill_nxt       = fill_r + count_t'(1);
        end
      end
      OP_REMOVE: begin
        if (found_w[CAPACITY-1]) begin
          out_status_nxt = ST_OK;
          fill_nxt       = fill_r - count_t'(1);
        end
      end
      OP_READ: begin
        if (pos_ok) begin
          out_status_nxt     = ST_OK;
          out_read_value_nxt = entry_w[read_idx[IDX_W-1:0]];
        end
      end
      default: begin
        out_status_nxt = ST_MISSING;
      end
    endcase
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        fill_r      <= fill_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_read_value_r <= out_read_value_nxt;
      out_status_r     <= out_status_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = out_read_value_r;
  assign out_status     = out_status_r;

  // Fill count never exceeds the capacity
  a_fill_bound : assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= count_t'(CAPACITY))
    else $error("fill count beyond capacity");

  // Fill count moves only on an accepted item
  a_fill_hold : assert property (@(posedge clk) disable iff (!rst_n)
    !in_acc |=> $stable(fill_r))
    else $error("fill count changed without an item");

  // Insert into a full store reports full and keeps the count
  a_full_drop : assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_op == OP_INSERT && full) |=>
      (out_status_r == ST_FULL && fill_r == count_t'(CAPACITY)))
    else $error("insert into full store not dropped");

  // Every accepted item leaves a result behind
  a_result : assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_valid_r)
    else $error("accepted item produced no result");

endmodule
